### sv/pcurv_pkg.sv
// ----------------------------------------------------------------------------
// Principal curvature package
// Shared constants, the pipeline item record and the arithmetic step
// functions used by the curvature pipeline.
// ----------------------------------------------------------------------------
package pcurv_pkg;

    // Fixed-point formats.
    localparam int VEC_FRAC_BITS = 14;
    localparam logic signed [15:0] VEC_ONE = 16'sd1 <<< VEC_FRAC_BITS;
    localparam logic signed [32:0] VEC_HALF = 33'sd1 <<< (VEC_FRAC_BITS - 1);
    localparam logic [16:0] THR_RESET = 17'd1;

    // Stage map of the pipeline.
    localparam int ST_PRE = 0;   // differences, magnitudes, ordering flags
    localparam int ST_MUL = 1;   // squares of |a| and |f|
    localparam int ST_ADD = 2;   // radicand for the eigenvalue spread
    localparam int ST_SQA = 3;   // first square root, two steps a stage
    localparam int SQA_N = 16;
    localparam int ST_PA = ST_SQA + SQA_N;      // P, A, curvatures
    localparam int ST_LOD = ST_PA + 1;          // leading one, umbilic test
    localparam int ST_SHF = ST_LOD + 1;         // scale P and A down
    localparam int ST_DIN = ST_SHF + 1;         // divider set-up
    localparam int ST_DCS = ST_DIN + 1;         // cos^2 / sin^2 division
    localparam int DCS_N = 8;
    localparam int DCS_STEPS = 29;
    localparam int ST_SQ2 = ST_DCS + DCS_N;     // square root set-up
    localparam int ST_SQB = ST_SQ2 + 1;         // cos / sin roots
    localparam int SQB_N = 4;
    localparam int SQB_FIRST = 17;
    localparam int ST_CS = ST_SQB + SQB_N;      // rotation coefficients
    localparam int ST_TPM = ST_CS + 1;          // tangent products
    localparam int ST_TMX = ST_TPM + 1;         // max direction rounding
    localparam int ST_XPR = ST_TMX + 1;         // cross product terms
    localparam int ST_XDF = ST_XPR + 1;         // cross product differences
    localparam int ST_MSQ = ST_XDF + 1;         // squared components
    localparam int ST_LSM = ST_MSQ + 1;         // squared length
    localparam int ST_SQC = ST_LSM + 1;         // length square root
    localparam int SQC_N = 16;
    localparam int ST_NIN = ST_SQC + SQC_N;     // normalising divider set-up
    localparam int ST_DVN = ST_NIN + 1;         // normalising division
    localparam int DVN_N = 4;
    localparam int DVN_STEPS = 15;
    localparam int ST_FIN = ST_DVN + DVN_N;     // signs, zeroing, saturation
    localparam int NSTAGE = ST_FIN + 1;

    // One vertex as it travels down the pipeline.
    typedef struct {
        logic signed [31:0] e;
        logic signed [31:0] f;
        logic signed [31:0] g;
        logic signed [15:0] u [3];
        logic signed [15:0] v [3];
        logic signed [15:0] n [3];
        logic signed [32:0] sum_eg;
        logic               fzero;
        logic               sneg;
        logic               noswap;
        logic [32:0]        ua;
        logic [31:0]        uf;
        logic [63:0]        ua2;
        logic [63:0]        uf2;
        logic [63:0]        sqx [2];
        logic [63:0]        sqr [2];
        logic [32:0]        pp;
        logic [32:0]        aa;
        logic [3:0]         sh;
        logic signed [34:0] hi;
        logic signed [34:0] lo;
        logic               umb;
        logic [32:0]        den;
        logic [32:0]        rem [3];
        logic [28:0]        nb [3];
        logic [28:0]        quo [3];
        logic signed [15:0] kx;
        logic signed [15:0] ky;
        logic signed [31:0] pu [3];
        logic signed [31:0] pv [3];
        logic signed [15:0] tmax [3];
        logic signed [31:0] p1 [3];
        logic signed [31:0] p2 [3];
        logic               mneg [3];
        logic [31:0]        mm [3];
        logic [63:0]        msq [3];
        logic [31:0]        len;
        logic signed [15:0] tmin [3];
        logic signed [31:0] cmax;
        logic signed [31:0] cmin;
    } item_t;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] res;
    } sq_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [28:0] nb;
        logic [28:0] quo;
    } dv_t;

    // One digit of the integer square root; step t uses bit 4^(31-t).
    function automatic sq_t isqrt_step(input sq_t s, input int t);
        logic [63:0] bitv;
        logic [63:0] trial;
        sq_t         r;
        bitv  = 64'd1 << (62 - 2 * t);
        trial = s.res + bitv;
        r     = s;
        if (s.x >= trial) begin
            r.x   = s.x - trial;
            r.res = (s.res >> 1) + bitv;
        end else begin
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    // One restoring division step: shift in the next numerator bit.
    function automatic dv_t div_step(input dv_t d, input logic [32:0] den);
        logic [33:0] tr;
        logic        qb;
        dv_t         r;
        tr = {d.rem, d.nb[28]};
        qb = 1'b0;
        if (tr >= {1'b0, den}) begin
            tr = tr - {1'b0, den};
            qb = 1'b1;
        end
        r.rem = tr[32:0];
        r.nb  = {d.nb[27:0], 1'b0};
        r.quo = {d.quo[27:0], qb};
        return r;
    endfunction

    // Round a Q2.28 sum to Q1.14 and saturate to 16 bits.
    function automatic logic signed [15:0] round_sat16(input logic signed [32:0] x);
        logic signed [32:0] r;
        r = (x + VEC_HALF) >>> VEC_FRAC_BITS;
        if (r > 33'sd32767) begin
            return 16'sh7fff;
        end else if (r < -33'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    // Saturate a curvature to the signed 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        if (x > 35'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -35'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

### sv/principal_curvature_from_tensor.sv
// ----------------------------------------------------------------------------
// Principal curvature from tensor
// Diagonalises a symmetric 2x2 curvature tensor by one Jacobi rotation and
// returns ordered principal curvatures and their directions in 3-D.
// ----------------------------------------------------------------------------
// The block takes one vertex beat per clock cycle while it is not stalled;
// the pipeline depth is set by the three pipelined square roots
// (32, 15 and 32 digits) and the two restoring dividers, each spread over
// stages of two or four digits. The stages stall together when the result
// beat is not taken, so nothing is lost or repeated. The umbilic threshold
// is written through the configuration channel, which is always ready, and
// should only change while no beat is in flight.
module principal_curvature_from_tensor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [16:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_tensor_e,
    input  logic signed [31:0]  s_tensor_f,
    input  logic signed [31:0]  s_tensor_g,
    input  logic signed [15:0]  s_frame_u_x,
    input  logic signed [15:0]  s_frame_u_y,
    input  logic signed [15:0]  s_frame_u_z,
    input  logic signed [15:0]  s_frame_v_x,
    input  logic signed [15:0]  s_frame_v_y,
    input  logic signed [15:0]  s_frame_v_z,
    input  logic signed [15:0]  s_normal_x,
    input  logic signed [15:0]  s_normal_y,
    input  logic signed [15:0]  s_normal_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_curv_max,
    output logic signed [31:0]  m_curv_min,
    output logic signed [15:0]  m_dir_max_x,
    output logic signed [15:0]  m_dir_max_y,
    output logic signed [15:0]  m_dir_max_z,
    output logic signed [15:0]  m_dir_min_x,
    output logic signed [15:0]  m_dir_min_y,
    output logic signed [15:0]  m_dir_min_z,
    output logic                m_umbilic
);
    import pcurv_pkg::*;

    item_t             in_item;
    item_t             pipe_reg  [NSTAGE];
    item_t             pipe_next [NSTAGE];
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [16:0]       thr_reg;
    logic              adv;

    // Work done by one stage of the pipeline.
    function automatic item_t stage_fn(input int k, input item_t d, input logic [16:0] thr);
        item_t              q;
        logic signed [32:0] a;
        logic [65:0]        sq66;
        logic [32:0]        pv;
        logic signed [34:0] p35;
        logic signed [34:0] sum35;
        logic signed [34:0] diff;
        logic [5:0]         bl;
        logic [22:0]        np;
        logic [22:0]        nm;
        logic [46:0]        num;
        logic signed [15:0] c16;
        logic signed [15:0] s16;
        logic signed [15:0] qv;
        logic signed [32:0] m33;
        sq_t                sq;
        dv_t                dv;
        int                 t;
        q = d;
        // Tensor differences and the ordering flags.
        if (k == ST_PRE) begin
            a        = 33'(d.g) - 33'(d.e);
            q.ua     = a[32] ? (~a + 33'd1) : a;
            q.uf     = d.f[31] ? (~d.f + 32'd1) : d.f;
            q.sum_eg = 33'(d.e) + 33'(d.g);
            q.fzero  = (d.f == 32'sd0);
            q.sneg   = (a != 33'sd0) && (a[32] != d.f[31]);
            q.noswap = (!a[32] && (a != 33'sd0)) ||
                       ((a == 33'sd0) && !d.f[31] && (d.f != 32'sd0));
            if (d.e > d.g) begin
                q.hi = 35'(d.e);
                q.lo = 35'(d.g);
            end else begin
                q.hi = 35'(d.g);
                q.lo = 35'(d.e);
            end
        end
        if (k == ST_MUL) begin
            sq66  = d.ua * d.ua;
            q.ua2 = sq66[63:0];
            q.uf2 = d.uf * d.uf;
        end
        if (k == ST_ADD) begin
            q.sqx[0] = {2'b00, d.ua2[63:2]} + d.uf2;
            q.sqr[0] = '0;
        end
        // Square root of the spread, all 32 digits.
        if (k >= ST_SQA && k < ST_SQA + SQA_N) begin
            for (int j = 0; j < 2; j++) begin
                t        = (k - ST_SQA) * 2 + j;
                sq       = isqrt_step('{x: q.sqx[0], res: q.sqr[0]}, t);
                q.sqx[0] = sq.x;
                q.sqr[0] = sq.res;
            end
        end
        // Twice the radius, the clipped difference and the curvatures.
        if (k == ST_PA) begin
            pv   = {d.sqr[0][31:0], 1'b0};
            q.pp = pv;
            q.aa = (d.ua < pv) ? d.ua : pv;
            if (!d.fzero) begin
                p35   = $signed({2'b00, pv});
                sum35 = 35'(d.sum_eg);
                q.hi  = (sum35 + p35) >>> 1;
                q.lo  = (sum35 - p35) >>> 1;
            end
        end
        // Leading one of P and the umbilic test.
        if (k == ST_LOD) begin
            bl = '0;
            for (int i = 0; i < 33; i++) begin
                if (d.pp[i]) begin
                    bl = 6'(i + 1);
                end
            end
            q.sh  = (bl > 6'd22) ? 4'(bl - 6'd22) : 4'd0;
            diff  = d.hi - d.lo;
            q.umb = diff < $signed({18'b0, thr});
        end
        if (k == ST_SHF) begin
            q.pp = d.pp >> d.sh;
            q.aa = d.aa >> d.sh;
        end
        // Divide (P +- A) << 28 by 2P; the top part is already below 2P.
        if (k == ST_DIN) begin
            np       = {1'b0, d.pp[21:0]} + {1'b0, d.aa[21:0]};
            nm       = {1'b0, d.pp[21:0]} - {1'b0, d.aa[21:0]};
            q.den    = {10'b0, d.pp[21:0], 1'b0};
            q.rem[0] = {11'b0, np[22:1]};
            q.rem[1] = {11'b0, nm[22:1]};
            q.nb[0]  = {np[0], 28'b0};
            q.nb[1]  = {nm[0], 28'b0};
            q.quo[0] = '0;
            q.quo[1] = '0;
        end
        if (k >= ST_DCS && k < ST_DCS + DCS_N) begin
            for (int j = 0; j < 4; j++) begin
                t = (k - ST_DCS) * 4 + j;
                if (t < DCS_STEPS) begin
                    for (int i = 0; i < 2; i++) begin
                        dv       = div_step('{rem: q.rem[i], nb: q.nb[i], quo: q.quo[i]},
                                            q.den);
                        q.rem[i] = dv.rem;
                        q.nb[i]  = dv.nb;
                        q.quo[i] = dv.quo;
                    end
                end
            end
        end
        if (k == ST_SQ2) begin
            for (int i = 0; i < 2; i++) begin
                q.sqx[i] = {35'b0, d.quo[i]};
                q.sqr[i] = '0;
            end
        end
        // Cosine and sine roots; the radicand stays below 2^29.
        if (k >= ST_SQB && k < ST_SQB + SQB_N) begin
            for (int j = 0; j < 4; j++) begin
                t = SQB_FIRST + (k - ST_SQB) * 4 + j;
                if (t < 32) begin
                    for (int i = 0; i < 2; i++) begin
                        sq       = isqrt_step('{x: q.sqx[i], res: q.sqr[i]}, t);
                        q.sqx[i] = sq.x;
                        q.sqr[i] = sq.res;
                    end
                end
            end
        end
        // Rotation coefficients, with the swap folded in.
        if (k == ST_CS) begin
            if (d.fzero) begin
                c16 = VEC_ONE;
                s16 = '0;
            end else begin
                c16 = $signed(d.sqr[0][15:0]);
                s16 = $signed(d.sqr[1][15:0]);
                if (d.sneg) begin
                    s16 = -s16;
                end
            end
            q.kx = d.noswap ? c16 : s16;
            q.ky = d.noswap ? -s16 : c16;
        end
        if (k == ST_TPM) begin
            for (int i = 0; i < 3; i++) begin
                q.pu[i] = d.kx * d.u[i];
                q.pv[i] = d.ky * d.v[i];
            end
        end
        if (k == ST_TMX) begin
            for (int i = 0; i < 3; i++) begin
                q.tmax[i] = round_sat16(33'(d.pu[i]) + 33'(d.pv[i]));
            end
        end
        // Cross product n x t_max.
        if (k == ST_XPR) begin
            q.p1[0] = d.n[1] * d.tmax[2];
            q.p2[0] = d.n[2] * d.tmax[1];
            q.p1[1] = d.n[2] * d.tmax[0];
            q.p2[1] = d.n[0] * d.tmax[2];
            q.p1[2] = d.n[0] * d.tmax[1];
            q.p2[2] = d.n[1] * d.tmax[0];
        end
        if (k == ST_XDF) begin
            for (int i = 0; i < 3; i++) begin
                m33       = 33'(d.p1[i]) - 33'(d.p2[i]);
                q.mneg[i] = m33[32];
                q.mm[i]   = m33[32] ? 32'(~m33 + 33'sd1) : m33[31:0];
            end
        end
        if (k == ST_MSQ) begin
            for (int i = 0; i < 3; i++) begin
                q.msq[i] = d.mm[i] * d.mm[i];
            end
        end
        if (k == ST_LSM) begin
            q.sqx[0] = d.msq[0] + d.msq[1] + d.msq[2];
            q.sqr[0] = '0;
        end
        if (k >= ST_SQC && k < ST_SQC + SQC_N) begin
            for (int j = 0; j < 2; j++) begin
                t        = (k - ST_SQC) * 2 + j;
                sq       = isqrt_step('{x: q.sqx[0], res: q.sqr[0]}, t);
                q.sqx[0] = sq.x;
                q.sqr[0] = sq.res;
            end
        end
        // Rounded division of each component by the length.
        if (k == ST_NIN) begin
            q.len = d.sqr[0][31:0];
            q.den = {1'b0, d.sqr[0][31:0]};
            for (int i = 0; i < 3; i++) begin
                num      = {1'b0, d.mm[i], 14'b0} + {16'b0, d.sqr[0][31:1]};
                q.rem[i] = {1'b0, num[46:15]};
                q.nb[i]  = {num[14:0], 14'b0};
                q.quo[i] = '0;
            end
        end
        if (k >= ST_DVN && k < ST_DVN + DVN_N) begin
            for (int j = 0; j < 4; j++) begin
                t = (k - ST_DVN) * 4 + j;
                if (t < DVN_STEPS) begin
                    for (int i = 0; i < 3; i++) begin
                        dv       = div_step('{rem: q.rem[i], nb: q.nb[i], quo: q.quo[i]},
                                            q.den);
                        q.rem[i] = dv.rem;
                        q.nb[i]  = dv.nb;
                        q.quo[i] = dv.quo;
                    end
                end
            end
        end
        // Signs, umbilic zeroing and curvature saturation.
        if (k == ST_FIN) begin
            for (int i = 0; i < 3; i++) begin
                qv = $signed({1'b0, d.quo[i][14:0]});
                if (d.len == 32'd0) begin
                    q.tmin[i] = '0;
                end else begin
                    q.tmin[i] = d.mneg[i] ? -qv : qv;
                end
                if (d.umb) begin
                    q.tmax[i] = '0;
                    q.tmin[i] = '0;
                end
            end
            q.cmax = sat32(d.hi);
            q.cmin = sat32(d.lo);
        end
        return q;
    endfunction

    // The whole pipeline moves when its last beat is empty or being taken.
    assign adv       = !vld_reg[NSTAGE-1] || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign vld_next  = {vld_reg[NSTAGE-2:0], s_valid};

    // Input beat into the pipeline record.
    always_comb begin
        in_item      = '{default: '0};
        in_item.e    = s_tensor_e;
        in_item.f    = s_tensor_f;
        in_item.g    = s_tensor_g;
        in_item.u[0] = s_frame_u_x;
        in_item.u[1] = s_frame_u_y;
        in_item.u[2] = s_frame_u_z;
        in_item.v[0] = s_frame_v_x;
        in_item.v[1] = s_frame_v_y;
        in_item.v[2] = s_frame_v_z;
        in_item.n[0] = s_normal_x;
        in_item.n[1] = s_normal_y;
        in_item.n[2] = s_normal_z;
    end

    // Next value of every stage.
    always_comb begin
        for (int k = 0; k < NSTAGE; k++) begin
            if (k == 0) begin
                pipe_next[k] = stage_fn(k, in_item, thr_reg);
            end else begin
                pipe_next[k] = stage_fn(k, pipe_reg[k-1], thr_reg);
            end
        end
    end

    // Valid bits and the threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            thr_reg <= THR_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (adv) begin
                vld_reg <= vld_next;
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg <= pipe_next;
        end
    end

    // Result beat.
    assign m_valid     = vld_reg[NSTAGE-1];
    assign m_curv_max  = pipe_reg[NSTAGE-1].cmax;
    assign m_curv_min  = pipe_reg[NSTAGE-1].cmin;
    assign m_dir_max_x = pipe_reg[NSTAGE-1].tmax[0];
    assign m_dir_max_y = pipe_reg[NSTAGE-1].tmax[1];
    assign m_dir_max_z = pipe_reg[NSTAGE-1].tmax[2];
    assign m_dir_min_x = pipe_reg[NSTAGE-1].tmin[0];
    assign m_dir_min_y = pipe_reg[NSTAGE-1].tmin[1];
    assign m_dir_min_z = pipe_reg[NSTAGE-1].tmin[2];
    assign m_umbilic   = pipe_reg[NSTAGE-1].umb;

endmodule
